/* hw/rtl/aep_pkg.sv */
// ----------------------------------------------------------------------------
// aep_pkg
// Shared types, codes, S-box tables and round functions for the AES-ECB
// byte-stream engine with PKCS#7 padding.
// ----------------------------------------------------------------------------
package aep_pkg;

  // Request kinds on the input channel.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_FIN   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_REJECT = 2'd1;
  localparam logic [1:0] STAT_NOHELD = 2'd2;
  localparam logic [1:0] STAT_BADPAD = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_KEY0  = 3'd0;
  localparam logic [2:0] CFG_KEY1  = 3'd1;
  localparam logic [2:0] CFG_KEY2  = 3'd2;
  localparam logic [2:0] CFG_KEY3  = 3'd3;
  localparam logic [2:0] CFG_KSIZE = 3'd4;
  localparam logic [2:0] CFG_DEC   = 3'd5;

  localparam int NUM_RK = 15;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } aep_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic [1:0] status;
  } aep_out_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Apply the S-box to each byte of a word.
  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // One forward round: SubBytes, ShiftRows, MixColumns unless final, AddRoundKey.
  function automatic logic [127:0] enc_round(input logic [127:0] s,
                                             input logic [127:0] rk,
                                             input logic         fin);
    logic [7:0]   a [16];
    logic [7:0]   t [16];
    logic [7:0]   m [16];
    logic [127:0] r;
    for (int j = 0; j < 16; j++) a[j] = SBOX[s[127-8*j -: 8]];
    for (int c = 0; c < 4; c++)
      for (int j = 0; j < 4; j++) t[j+4*c] = a[j+4*((c+j)%4)];
    for (int c = 0; c < 4; c++) begin
      m[4*c]   = xt(t[4*c]) ^ xt(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c+1] = t[4*c] ^ xt(t[4*c+1]) ^ xt(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
      m[4*c+2] = t[4*c] ^ t[4*c+1] ^ xt(t[4*c+2]) ^ xt(t[4*c+3]) ^ t[4*c+3];
      m[4*c+3] = xt(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xt(t[4*c+3]);
    end
    for (int j = 0; j < 16; j++) r[127-8*j -: 8] = fin ? t[j] : m[j];
    return r ^ rk;
  endfunction

  // One inverse round: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns unless final.
  function automatic logic [127:0] dec_round(input logic [127:0] s,
                                             input logic [127:0] rk,
                                             input logic         fin);
    logic [7:0]   t [16];
    logic [7:0]   a [16];
    logic [7:0]   x2, x4, x8;
    logic [7:0]   m9 [16];
    logic [7:0]   m11 [16];
    logic [7:0]   m13 [16];
    logic [7:0]   m14 [16];
    logic [127:0] r;
    for (int c = 0; c < 4; c++)
      for (int j = 0; j < 4; j++) t[j+4*((c+j)%4)] = s[127-8*(j+4*c) -: 8];
    for (int j = 0; j < 16; j++) begin
      a[j]   = INV_SBOX[t[j]] ^ rk[127-8*j -: 8];
      x2     = xt(a[j]);
      x4     = xt(x2);
      x8     = xt(x4);
      m9[j]  = x8 ^ a[j];
      m11[j] = x8 ^ x2 ^ a[j];
      m13[j] = x8 ^ x4 ^ a[j];
      m14[j] = x8 ^ x4 ^ x2;
    end
    for (int c = 0; c < 4; c++) begin
      r[127-8*(4*c)   -: 8] = fin ? a[4*c] :
                              m14[4*c] ^ m11[4*c+1] ^ m13[4*c+2] ^ m9[4*c+3];
      r[127-8*(4*c+1) -: 8] = fin ? a[4*c+1] :
                              m9[4*c] ^ m14[4*c+1] ^ m11[4*c+2] ^ m13[4*c+3];
      r[127-8*(4*c+2) -: 8] = fin ? a[4*c+2] :
                              m13[4*c] ^ m9[4*c+1] ^ m14[4*c+2] ^ m11[4*c+3];
      r[127-8*(4*c+3) -: 8] = fin ? a[4*c+3] :
                              m11[4*c] ^ m13[4*c+1] ^ m9[4*c+2] ^ m14[4*c+3];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/aes_ecb_pkcs7_stream.sv */
// ----------------------------------------------------------------------------
// aes_ecb_pkcs7_stream
// Byte-stream AES-ECB engine with PKCS#7 padding and removal.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (in_valid / in_stall) carry a kind and a data byte: data,
//   finalize or clear. Results leave on out_valid / out_stall, one byte or
//   status per result, with last marking the final result of a request.
//   The config port (cfg_valid / cfg_ready) writes key words, key size and
//   mode; each write re-expands the key schedule, one 32-bit word per cycle,
//   during which neither channel takes a request.
// Timing:
//   A data byte that does not complete a block runs no round. A block is
//   run through one shared round unit, one round per cycle: the first key
//   add, then 10, 12 or 14 rounds, a padding check for a decrypt finalize,
//   then one result per cycle out of the output register while the
//   receiver does not stall. A request that runs a block holds off input
//   until its last result is registered.
// Reset:
//   Synchronous active-low reset clears the stream, the key and the mode and
//   expands the all-zero 128-bit key before the first request is taken.
// Stall:
//   While out_stall is high a valid result stays in the output register and
//   the sequencer waits before writing another; no result is lost or repeated.
// ----------------------------------------------------------------------------
module aes_ecb_pkcs7_stream
  import aep_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  aep_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output aep_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_KEYX  = 3'd1;
  localparam logic [2:0] ST_ADDK  = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;
  localparam logic [2:0] ST_STAT  = 3'd6;

  logic [2:0]   state_r;
  logic [63:0]  key_r [4];
  logic [1:0]   ksz_r;
  logic         dec_r;
  logic [127:0] asm_r;
  logic [3:0]   fill_r;
  logic [127:0] held_r;
  logic         held_v_r;
  logic         fin_r;
  logic [127:0] rk_r [NUM_RK];
  logic [31:0]  win_r [8];
  logic [5:0]   ki_r;
  logic [2:0]   kc_r;
  logic [7:0]   rc_r;
  logic [127:0] st_r;
  logic [3:0]   rnd_r;
  logic         op_dec_r;
  logic         chk_r;
  logic [4:0]   em_left_r;
  logic [3:0]   em_idx_r;
  logic [1:0]   stat_r;
  logic         out_valid_r;
  aep_out_t     out_r;

  logic [3:0]   nk;
  logic [2:0]   nk_m1;
  logic [3:0]   nr;
  logic [5:0]   total;
  logic [255:0] kcat;
  logic [7:0]   koff;
  logic [6:0]   woff;
  logic [31:0]  kw_new;
  logic [31:0]  kt;
  logic [7:0]   rc_nxt;
  logic [127:0] rk_rd;
  logic         in_acc;
  logic         out_free;
  logic [127:0] asm_nxt;
  logic [127:0] padded;
  logic [7:0]   pad_fill;
  logic [7:0]   pad;
  logic         bad_pad;
  logic         rnd_last;
  logic [127:0] round_out;
  logic [6:0]   boff;

  // Key size decode; a size code of 3 runs as a 256-bit key.
  always_comb begin
    case (ksz_r)
      2'd0:    nk = 4'd4;
      2'd1:    nk = 4'd6;
      default: nk = 4'd8;
    endcase
    nk_m1 = 3'(nk - 4'd1);
    nr    = nk + 4'd6;
    total = {nr + 4'd1, 2'b00};
  end

  // Key expansion word: initial key words, then the schedule recurrence.
  always_comb begin
    kcat   = {key_r[0], key_r[1], key_r[2], key_r[3]};
    koff   = {3'(3'd7 - ki_r[2:0]), 5'b0};
    woff   = {2'(2'd3 - ki_r[1:0]), 5'b0};
    kt     = win_r[0];
    rc_nxt = rc_r;
    if (kc_r == 3'd0) begin
      kt     = sub_word({kt[23:0], kt[31:24]}) ^ {rc_r, 24'h0};
      rc_nxt = xt(rc_r);
    end else if (nk == 4'd8 && kc_r == 3'd4) begin
      kt = sub_word(kt);
    end
    if (ki_r < 6'(nk)) kw_new = kcat[koff +: 32];
    else               kw_new = win_r[nk_m1] ^ kt;
  end

  // Round datapath shared by both directions.
  assign rk_rd     = rk_r[rnd_r];
  assign rnd_last  = op_dec_r ? (rnd_r == 4'd0) : (rnd_r == nr);
  assign round_out = op_dec_r ? dec_round(st_r, rk_rd, rnd_last)
                              : enc_round(st_r, rk_rd, rnd_last);

  // Handshakes.
  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Block assembly and finalize padding.
  always_comb begin
    asm_nxt  = asm_r;
    asm_nxt[{4'(4'd15 - fill_r), 3'b0} +: 8] = in_data.data_byte;
    pad_fill = 8'd16 - {4'b0, fill_r};
    for (int i = 0; i < 16; i++)
      padded[127-8*i -: 8] = (4'(i) < fill_r) ? asm_r[127-8*i -: 8] : pad_fill;
  end

  // PKCS#7 check of the decrypted block.
  always_comb begin
    pad     = st_r[7:0];
    bad_pad = (pad == 8'd0) || (pad > 8'd16);
    for (int i = 0; i < 16; i++)
      if (5'(i) >= 5'd16 - pad[4:0] && st_r[127-8*i -: 8] != pad && !(pad > 8'd16))
        bad_pad = 1'b1;
  end

  assign boff = {4'(4'd15 - em_idx_r), 3'b0};

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    if (state_r == ST_KEYX) begin
      rk_r[ki_r[5:2]][woff +: 32] <= kw_new;
      win_r[0] <= kw_new;
      for (int j = 1; j < 8; j++) win_r[j] <= win_r[j-1];
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_KEYX;
      ki_r        <= '0;
      kc_r        <= '0;
      rc_r        <= 8'h01;
      for (int k = 0; k < 4; k++) key_r[k] <= '0;
      ksz_r       <= '0;
      dec_r       <= 1'b0;
      fill_r      <= '0;
      held_v_r    <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_data.kind)
              KIND_CLEAR: begin
                fill_r   <= '0;
                held_v_r <= 1'b0;
                fin_r    <= 1'b0;
              end
              KIND_DATA: begin
                if (fin_r) begin
                  stat_r  <= STAT_REJECT;
                  state_r <= ST_STAT;
                end else begin
                  asm_r <= asm_nxt;
                  if (fill_r != 4'd15) begin
                    fill_r <= fill_r + 4'd1;
                  end else begin
                    fill_r <= '0;
                    chk_r  <= 1'b0;
                    if (!dec_r) begin
                      st_r     <= asm_nxt;
                      op_dec_r <= 1'b0;
                      rnd_r    <= '0;
                      state_r  <= ST_ADDK;
                    end else if (!held_v_r) begin
                      held_r   <= asm_nxt;
                      held_v_r <= 1'b1;
                    end else begin
                      st_r     <= held_r;
                      held_r   <= asm_nxt;
                      op_dec_r <= 1'b1;
                      rnd_r    <= nr;
                      state_r  <= ST_ADDK;
                    end
                  end
                end
              end
              KIND_FIN: begin
                if (fin_r) begin
                  stat_r  <= STAT_REJECT;
                  state_r <= ST_STAT;
                end else if (!dec_r) begin
                  st_r     <= padded;
                  fill_r   <= '0;
                  fin_r    <= 1'b1;
                  op_dec_r <= 1'b0;
                  chk_r    <= 1'b0;
                  rnd_r    <= '0;
                  state_r  <= ST_ADDK;
                end else if (!held_v_r) begin
                  stat_r  <= STAT_NOHELD;
                  state_r <= ST_STAT;
                end else begin
                  st_r     <= held_r;
                  op_dec_r <= 1'b1;
                  chk_r    <= 1'b1;
                  rnd_r    <= nr;
                  state_r  <= ST_ADDK;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_KEYX: begin
          ki_r <= ki_r + 6'd1;
          kc_r <= (kc_r == nk_m1) ? 3'd0 : kc_r + 3'd1;
          if (ki_r >= 6'(nk)) rc_r <= rc_nxt;
          if (ki_r == total - 6'd1) state_r <= ST_IDLE;
        end
        ST_ADDK: begin
          st_r    <= st_r ^ rk_rd;
          rnd_r   <= op_dec_r ? nr - 4'd1 : 4'd1;
          state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          st_r <= round_out;
          if (rnd_last) begin
            em_idx_r  <= '0;
            em_left_r <= 5'd16;
            state_r   <= chk_r ? ST_CHECK : ST_EMIT;
          end else begin
            rnd_r <= op_dec_r ? rnd_r - 4'd1 : rnd_r + 4'd1;
          end
        end
        ST_CHECK: begin
          if (bad_pad) begin
            stat_r  <= STAT_BADPAD;
            state_r <= ST_STAT;
          end else begin
            held_v_r <= 1'b0;
            fill_r   <= '0;
            fin_r    <= 1'b1;
            if (pad == 8'd16) begin
              stat_r  <= STAT_OK;
              state_r <= ST_STAT;
            end else begin
              em_left_r <= 5'd16 - pad[4:0];
              state_r   <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r      <= 1'b1;
            out_r.out_byte   <= st_r[boff +: 8];
            out_r.byte_valid <= 1'b1;
            out_r.last       <= (em_left_r == 5'd1);
            out_r.status     <= STAT_OK;
            em_idx_r         <= em_idx_r + 4'd1;
            em_left_r        <= em_left_r - 5'd1;
            if (em_left_r == 5'd1) state_r <= ST_IDLE;
          end
        end
        ST_STAT: begin
          if (out_free) begin
            out_valid_r      <= 1'b1;
            out_r.out_byte   <= 8'h00;
            out_r.byte_valid <= 1'b0;
            out_r.last       <= 1'b1;
            out_r.status     <= stat_r;
            state_r          <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      // Register writes restart the key schedule.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KEY0:  key_r[0] <= cfg_data;
          CFG_KEY1:  key_r[1] <= cfg_data;
          CFG_KEY2:  key_r[2] <= cfg_data;
          CFG_KEY3:  key_r[3] <= cfg_data;
          CFG_KSIZE: ksz_r    <= cfg_data[1:0];
          CFG_DEC:   dec_r    <= cfg_data[0];
          default: begin
          end
        endcase
        if (cfg_index <= CFG_DEC) begin
          state_r <= ST_KEYX;
          ki_r    <= '0;
          kc_r    <= '0;
          rc_r    <= 8'h01;
        end
      end
    end
  end

`ifndef SYNTHESIS
  // No request is taken while the key schedule is being built.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_KEYX) |-> (in_stall && !cfg_ready))
    else $error("request taken during key expansion");

  // A status-only result always closes its request.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.byte_valid) |-> (out_r.last && out_r.out_byte == 8'h00))
    else $error("status result malformed");

  // A data result never carries an error status.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.byte_valid) |-> (out_r.status == STAT_OK))
    else $error("data result with error status");
`endif

endmodule
